[rtl/ddd_pkg.sv]
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and lookup functions for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int CORR_W  = 10;
   localparam int Q100_W  = 8;

   localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

   // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for y < 2**14
   localparam int RECIP_SHIFT = 20;
   localparam logic [YEAR_W-1:0] RECIP_100 = YEAR_W'(10486);

   localparam logic signed [1:0] ORDER_LATER   = 2'sd1;
   localparam logic signed [1:0] ORDER_EARLIER = -2'sd1;
   localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   typedef struct packed {
      logic [DAY_W-1:0]   day_a;
      logic [MONTH_W-1:0] month_a;
      logic [YEAR_W-1:0]  year_a;
      logic [DAY_W-1:0]   day_b;
      logic [MONTH_W-1:0] month_b;
      logic [YEAR_W-1:0]  year_b;
   } req_type;

   typedef struct packed {
      logic signed [1:0]  order;
      logic [COUNT_W-1:0] day_count;
      logic               dates_valid;
   } rsp_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      unique case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [DAY_W-1:0] n;
      if (m == MONTH_FEB) begin
         n = leap ? DAY_W'(29) : DAY_W'(28);
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                   m == MONTH_NOV) begin
         n = DAY_W'(30);
      end else begin
         n = DAY_W'(31);
      end
      return n;
   endfunction

endpackage

[rtl/date_difference_in_days_top.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days_top
// Order and absolute day distance between two Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pair of dates (A and B) per transfer; rsp_* returns one
//   result per request, in order: order (+1 A later, -1 A earlier, 0 equal),
//   day_count (absolute days between the dates) and dates_valid. When either
//   date is not a real calendar date in years 1..9999, dates_valid is 0 and
//   day_count is 0; order still compares the raw (year, month, day) fields.
//   rsp_valid rises once the result reaches the stage 4 output register. A
//   new request is taken every cycle while the output is not stalled, since
//   each of the four stages passes one item per cycle:
//   reciprocal multiply for year/100, serial-day partial sums, serial-day
//   add, and the subtract and magnitude select into the output register.
//   Each stage holds its own valid bit, so bubbles collapse. When the
//   receiver stalls, results stay in the pipeline and req_ready drops only
//   once every stage is full; nothing is lost or repeated.
//   Reset (synchronous, active high) clears all stage valid bits; the stage
//   data registers are not reset.
// ----------------------------------------------------------------------------
module date_difference_in_days_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ddd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ddd_pkg::rsp_type  rsp_data
);

   localparam int DW = ddd_pkg::DAY_W;
   localparam int MW = ddd_pkg::MONTH_W;
   localparam int YW = ddd_pkg::YEAR_W;
   localparam int CW = ddd_pkg::COUNT_W;
   localparam int RW = ddd_pkg::CORR_W;
   localparam int QW = ddd_pkg::Q100_W;
   localparam int PW = 2 * YW;

   // stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   // stage 1
   logic [DW-1:0] day_s1_ff [2];
   logic [MW-1:0] month_s1_ff [2];
   logic [YW-1:0] year_s1_ff [2];
   logic [QW-1:0] q_s1_ff [2];
   logic signed [1:0] order_s1_ff;
   logic [DW-1:0] day_s1_in [2];
   logic [MW-1:0] month_s1_in [2];
   logic [YW-1:0] year_s1_in [2];
   logic [QW-1:0] q_s1_in [2];
   logic signed [1:0] order_s1_in;

   // stage 2
   logic [CW-1:0] base_s2_ff [2];
   logic [RW-1:0] corr_s2_ff [2];
   logic          ok_s2_ff [2];
   logic signed [1:0] order_s2_ff;
   logic [CW-1:0] base_s2_in [2];
   logic [RW-1:0] corr_s2_in [2];
   logic          ok_s2_in [2];

   // stage 3
   logic [CW-1:0] serial_s3_ff [2];
   logic          valid_s3_ff;
   logic signed [1:0] order_s3_ff;
   logic [CW-1:0] serial_s3_in [2];
   logic          valid_s3_in;

   // stage 4 (output)
   ddd_pkg::rsp_type rsp_ff;
   ddd_pkg::rsp_type rsp_in;

   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   // stage 1: capture, year/100 by reciprocal, raw-key compare
   always_comb begin
      logic [PW-1:0]     prod;
      logic [DW+MW+YW-1:0] key_a;
      logic [DW+MW+YW-1:0] key_b;
      day_s1_in[0]   = req_data.day_a;
      month_s1_in[0] = req_data.month_a;
      year_s1_in[0]  = req_data.year_a;
      day_s1_in[1]   = req_data.day_b;
      month_s1_in[1] = req_data.month_b;
      year_s1_in[1]  = req_data.year_b;
      for (int i = 0; i < 2; i++) begin
         prod       = PW'(year_s1_in[i]) * PW'(ddd_pkg::RECIP_100);
         q_s1_in[i] = prod[ddd_pkg::RECIP_SHIFT +: QW];
      end
      key_a = {req_data.year_a, req_data.month_a, req_data.day_a};
      key_b = {req_data.year_b, req_data.month_b, req_data.day_b};
      if (key_a > key_b) begin
         order_s1_in = ddd_pkg::ORDER_LATER;
      end else if (key_a < key_b) begin
         order_s1_in = ddd_pkg::ORDER_EARLIER;
      end else begin
         order_s1_in = ddd_pkg::ORDER_EQUAL;
      end
   end

   // stage 2: leap year, validity, serial-day partial sums
   always_comb begin
      logic [YW-1:0] r_full;
      logic [6:0]    r100;
      logic          leap;
      logic [DW-1:0] mlen;
      logic [YW-1:0] p;
      logic [QW-1:0] q100p;
      logic          adj;
      for (int i = 0; i < 2; i++) begin
         r_full = year_s1_ff[i] - YW'(q_s1_ff[i]) * YW'(100);
         r100   = r_full[6:0];
         leap   = (year_s1_ff[i][1:0] == 2'd0) &&
                  ((r100 != 7'd0) || (q_s1_ff[i][1:0] == 2'd0));
         mlen   = ddd_pkg::month_length(month_s1_ff[i], leap);
         ok_s2_in[i] = (month_s1_ff[i] >= ddd_pkg::MONTH_JAN) &&
                       (month_s1_ff[i] <= ddd_pkg::MONTH_DEC) &&
                       (year_s1_ff[i] != YW'(0)) &&
                       (year_s1_ff[i] <= ddd_pkg::MAX_YEAR) &&
                       (day_s1_ff[i] != DW'(0)) &&
                       (day_s1_ff[i] <= mlen);
         p     = year_s1_ff[i] - YW'(1);
         q100p = q_s1_ff[i] - QW'(r100 == 7'd0);
         adj   = leap && (month_s1_ff[i] > ddd_pkg::MONTH_FEB);
         base_s2_in[i] = CW'(CW'(p) * CW'(365)) + CW'(p[YW-1:2]);
         corr_s2_in[i] = RW'(ddd_pkg::days_before_month(month_s1_ff[i])) +
                         RW'(day_s1_ff[i]) + RW'(adj) - RW'(q100p) +
                         RW'(q100p[QW-1:2]);
      end
   end

   // stage 3: serial day number
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         serial_s3_in[i] = base_s2_ff[i] +
                           {{(CW-RW){corr_s2_ff[i][RW-1]}}, corr_s2_ff[i]};
      end
      valid_s3_in = ok_s2_ff[0] && ok_s2_ff[1];
   end

   // stage 4: magnitude of difference
   always_comb begin
      logic [CW-1:0] d_ab;
      logic [CW-1:0] d_ba;
      d_ab = serial_s3_ff[0] - serial_s3_ff[1];
      d_ba = serial_s3_ff[1] - serial_s3_ff[0];
      rsp_in.order       = order_s3_ff;
      rsp_in.dates_valid = valid_s3_ff;
      if (!valid_s3_ff) begin
         rsp_in.day_count = '0;
      end else if (serial_s3_ff[0] >= serial_s3_ff[1]) begin
         rsp_in.day_count = d_ab;
      end else begin
         rsp_in.day_count = d_ba;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         day_s1_ff   <= day_s1_in;
         month_s1_ff <= month_s1_in;
         year_s1_ff  <= year_s1_in;
         q_s1_ff     <= q_s1_in;
         order_s1_ff <= order_s1_in;
      end
      if (adv2) begin
         base_s2_ff  <= base_s2_in;
         corr_s2_ff  <= corr_s2_in;
         ok_s2_ff    <= ok_s2_in;
         order_s2_ff <= order_s1_ff;
      end
      if (adv3) begin
         serial_s3_ff <= serial_s3_in;
         valid_s3_ff  <= valid_s3_in;
         order_s3_ff  <= order_s2_ff;
      end
      if (adv4) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
